FILE: src/jcq_pkg.sv
// Shared types, constants and quantization tables for the JPEG coefficient quantizer.
// Used by the stream interfaces, the pipelined divider and the top level.
// No dependencies.
package jcq_pkg;

    // Field widths of a beat.
    localparam int VALUE_BITS      = 23;
    localparam int SCALE_FRAC_BITS = 8;
    localparam int SCALE_BITS      = 12;
    localparam int TAB_BITS        = 7;
    localparam int POS_BITS        = 6;
    localparam int CHAN_BITS       = 2;

    // Derived datapath widths.
    localparam int D_BITS     = TAB_BITS + SCALE_BITS;
    localparam int DEN_BITS   = D_BITS + 1;
    localparam int NUM_BITS   = ((VALUE_BITS + SCALE_FRAC_BITS) > D_BITS ?
                                 (VALUE_BITS + SCALE_FRAC_BITS) : D_BITS) + 1;
    localparam int DIV_STEP   = 4;
    localparam int DIV_STAGES = (NUM_BITS + DIV_STEP - 1) / DIV_STEP;
    localparam int NUM_PAD    = DIV_STAGES * DIV_STEP;
    localparam int PROD_BITS  = VALUE_BITS + D_BITS;

    // Reset value of the scale register (1.0).
    localparam logic [SCALE_BITS-1:0] SCALE_RESET = SCALE_BITS'(2 ** SCALE_FRAC_BITS);

    // Rounding term added before the fraction bits are dropped.
    localparam logic [PROD_BITS:0] DEQ_RND = (PROD_BITS + 1)'((2 ** SCALE_FRAC_BITS) / 2);

    // Saturation limits of the result magnitude.
    localparam logic [VALUE_BITS-1:0] LIM_NEG = {1'b1, {(VALUE_BITS - 1){1'b0}}};
    localparam logic [VALUE_BITS-1:0] LIM_POS = {1'b0, {(VALUE_BITS - 1){1'b1}}};

    // Channel code that selects the luminance table.
    localparam logic [CHAN_BITS-1:0] CHAN_LUMA = 2'd0;

    // Operation codes.
    typedef enum logic {
        CMD_QUANT   = 1'b0,
        CMD_DEQUANT = 1'b1
    } t_cmd;

    // Side information that rides along with the divider.
    typedef struct packed {
        t_cmd                  cmd;
        logic                  neg;
        logic                  dz;
        logic                  mnz;
        logic                  dsat;
        logic [VALUE_BITS-1:0] dmag;
    } t_tag;

    // Luminance table, row-major.
    localparam logic [TAB_BITS-1:0] LUMA_TAB [64] = '{
        16, 11, 10, 16, 24, 40, 51, 61,
        12, 12, 14, 19, 26, 58, 60, 55,
        14, 13, 16, 24, 40, 57, 69, 56,
        14, 17, 22, 29, 51, 87, 80, 62,
        18, 22, 37, 56, 68, 109, 103, 77,
        24, 35, 55, 64, 81, 104, 113, 92,
        79, 64, 78, 87, 103, 121, 120, 101,
        72, 92, 95, 98, 112, 100, 103, 99
    };

    // Standard chrominance table, row-major.
    localparam logic [TAB_BITS-1:0] CHROMA_TAB [64] = '{
        17, 18, 24, 47, 99, 99, 99, 99,
        18, 21, 26, 66, 99, 99, 99, 99,
        24, 26, 56, 99, 99, 99, 99, 99,
        47, 66, 99, 99, 99, 99, 99, 99,
        99, 99, 99, 99, 99, 99, 99, 99,
        99, 99, 99, 99, 99, 99, 99, 99,
        99, 99, 99, 99, 99, 99, 99, 99,
        99, 99, 99, 99, 99, 99, 99, 99
    };

endpackage

FILE: src/jcq_stream_if.sv
// Valid/ready stream interfaces for coefficient beats in and result beats out.
// Depends on jcq_pkg for the field widths.

// Input channel: one coefficient with its command, channel and position.
interface jcq_in_if import jcq_pkg::*; ();
    logic                         valid;
    logic                         ready;
    logic                         command;
    logic [CHAN_BITS-1:0]         channel;
    logic [POS_BITS-1:0]          position;
    logic signed [VALUE_BITS-1:0] coefficient;

    modport source (output valid, command, channel, position, coefficient, input ready);
    modport sink   (input valid, command, channel, position, coefficient, output ready);
endinterface

// Output channel: one result value and its saturation flag.
interface jcq_out_if import jcq_pkg::*; ();
    logic                         valid;
    logic                         ready;
    logic signed [VALUE_BITS-1:0] value;
    logic                         saturated;

    modport source (output valid, value, saturated, input ready);
    modport sink   (input valid, value, saturated, output ready);
endinterface

FILE: src/jcq_div_pipe.sv
// Pipelined restoring divider, DIV_STEP quotient bits per stage, with a side tag.
// Depends on jcq_pkg for widths and the tag type.
module jcq_div_pipe import jcq_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  logic [NUM_PAD-1:0]  i_num,
    input  logic [DEN_BITS-1:0] i_den,
    input  t_tag                i_tag,
    output logic                o_valid,
    input  logic                i_ready,
    output logic [NUM_PAD-1:0]  o_quot,
    output t_tag                o_tag
);

    // Stage registers: numerator bits shift out as quotient bits shift in.
    logic [DIV_STAGES-1:0] r_vld;
    logic [NUM_PAD-1:0]    r_nq  [DIV_STAGES];
    logic [DEN_BITS-1:0]   r_rem [DIV_STAGES];
    logic [DEN_BITS-1:0]   r_den [DIV_STAGES];
    t_tag                  r_tag [DIV_STAGES];

    // Stage inputs: index 0 is the port, index s+1 is stage s.
    logic [DIV_STAGES:0]   w_vld;
    logic [NUM_PAD-1:0]    w_nq  [DIV_STAGES+1];
    logic [DEN_BITS-1:0]   w_rem [DIV_STAGES+1];
    logic [DEN_BITS-1:0]   w_den [DIV_STAGES+1];
    t_tag                  w_tag [DIV_STAGES+1];
    logic [DIV_STAGES:0]   w_go;

    assign w_vld[0] = i_valid;
    assign w_nq[0]  = i_num;
    assign w_rem[0] = '0;
    assign w_den[0] = i_den;
    assign w_tag[0] = i_tag;
    assign w_go[DIV_STAGES] = i_ready;

    genvar s;
    generate
        for (s = 0; s < DIV_STAGES; s++) begin : g_stage
            logic [NUM_PAD-1:0]  n_nq;
            logic [DEN_BITS-1:0] n_rem;

            // A stage loads when it is empty or its content moves on.
            assign w_go[s] = !r_vld[s] || w_go[s+1];

            // DIV_STEP trial subtractions on the running remainder.
            always_comb begin
                logic [NUM_PAD-1:0]  nq;
                logic [DEN_BITS-1:0] rem;
                logic [DEN_BITS:0]   trial;
                nq  = w_nq[s];
                rem = w_rem[s];
                for (int k = 0; k < DIV_STEP; k++) begin
                    trial = {rem, nq[NUM_PAD-1]};
                    nq    = {nq[NUM_PAD-2:0], 1'b0};
                    if (trial >= {1'b0, w_den[s]}) begin
                        trial = trial - {1'b0, w_den[s]};
                        nq[0] = 1'b1;
                    end
                    rem = trial[DEN_BITS-1:0];
                end
                n_nq  = nq;
                n_rem = rem;
            end

            // Valid bit under reset; payload only follows the enable.
            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_vld[s] <= 1'b0;
                end else if (w_go[s]) begin
                    r_vld[s] <= w_vld[s];
                end
            end

            always_ff @(posedge i_clk) begin
                if (w_go[s]) begin
                    r_nq[s]  <= n_nq;
                    r_rem[s] <= n_rem;
                    r_den[s] <= w_den[s];
                    r_tag[s] <= w_tag[s];
                end
            end

            assign w_vld[s+1] = r_vld[s];
            assign w_nq[s+1]  = r_nq[s];
            assign w_rem[s+1] = r_rem[s];
            assign w_den[s+1] = r_den[s];
            assign w_tag[s+1] = r_tag[s];
        end
    endgenerate

    assign o_ready = w_go[0];
    assign o_valid = r_vld[DIV_STAGES-1];
    assign o_quot  = r_nq[DIV_STAGES-1];
    assign o_tag   = r_tag[DIV_STAGES-1];

    // The final remainder always stays below a nonzero divisor.
    a_rem_below_den: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && r_den[DIV_STAGES-1] != '0) |->
            (r_rem[DIV_STAGES-1] < r_den[DIV_STAGES-1]))
        else $error("divider remainder not below divisor");

    // The divider only refuses a beat when every stage is occupied.
    a_full_when_blocked: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_ready |-> (&r_vld))
        else $error("divider stalls its input with an empty stage");

    // A waiting result beat holds still until it is taken.
    a_out_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready) |=> (o_valid && $stable(o_quot) && $stable(o_tag)))
        else $error("divider result changed while stalled");

endmodule

FILE: src/jpeg_coefficient_quantizer.sv
// JPEG baseline quantizer and dequantizer: top level with front stages and output register.
// Depends on jcq_pkg, jcq_stream_if and jcq_div_pipe.
//
// Usage:
//   Input beats on i_in carry command, channel, position and coefficient; each beat
//   produces exactly one result beat on o_out carrying value and saturated.
//   Quantize divides by table entry times scale, rounding half away from zero;
//   dequantize multiplies by the same product and rounds. Results clip to the
//   signed value range and raise saturated when clipped.
//   i_cfg_we / i_cfg_wdata write the scale register; the user must do so only while no
//   beat is in flight; the block does not enforce this. It resets to 256 (a scale of 1.0).
// Timing:
//   Each input beat passes three front stages (table lookup, table times scale,
//   numerator and product), DIV_STAGES = 8 divider stages of four quotient bits
//   each, and the output register. Throughput is one beat per cycle while the
//   receiver takes results; every stage holds its own valid bit.
// Reset and stalls:
//   Synchronous active-low reset empties all stages and reloads the scale.
//   When the receiver stalls, the pipeline keeps moving until its stages are
//   full, and only then drops i_in.ready; no beat is lost or repeated.
module jpeg_coefficient_quantizer import jcq_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [SCALE_BITS-1:0] i_cfg_wdata,
    jcq_in_if.sink                i_in,
    jcq_out_if.source             o_out
);

    // Scale register.
    logic [SCALE_BITS-1:0] r_scale;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scale <= SCALE_RESET;
        end else if (i_cfg_we) begin
            r_scale <= i_cfg_wdata;
        end
    end

    // Stage enables, back to front.
    logic w_go0, w_go1, w_go2, w_out_go, w_div_ready;
    logic r0_vld, r1_vld, r2_vld, r_ov;

    assign w_out_go = !r_ov || o_out.ready;
    assign w_go2    = !r2_vld || w_div_ready;
    assign w_go1    = !r1_vld || w_go2;
    assign w_go0    = !r0_vld || w_go1;
    assign i_in.ready = w_go0;

    // Stage 0: sign split, magnitude and table lookup.
    logic [VALUE_BITS-1:0] w_coef;
    logic                  w_neg;
    logic [VALUE_BITS-1:0] w_mag;
    logic [TAB_BITS-1:0]   w_tab;
    t_cmd                  r0_cmd;
    logic                  r0_neg;
    logic [VALUE_BITS-1:0] r0_mag;
    logic [TAB_BITS-1:0]   r0_tab;

    assign w_coef = i_in.coefficient;
    assign w_neg  = w_coef[VALUE_BITS-1];
    assign w_mag  = w_neg ? (~w_coef + {{(VALUE_BITS - 1){1'b0}}, 1'b1}) : w_coef;
    assign w_tab  = (i_in.channel == CHAN_LUMA) ? LUMA_TAB[i_in.position]
                                                : CHROMA_TAB[i_in.position];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r0_vld <= 1'b0;
        end else if (w_go0) begin
            r0_vld <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_go0) begin
            r0_cmd <= t_cmd'(i_in.command);
            r0_neg <= w_neg;
            r0_mag <= w_mag;
            r0_tab <= w_tab;
        end
    end

    // Stage 1: divisor d = table entry times scale.
    t_cmd                  r1_cmd;
    logic                  r1_neg;
    logic [VALUE_BITS-1:0] r1_mag;
    logic [D_BITS-1:0]     r1_d;
    logic [D_BITS-1:0]     n_d;

    assign n_d = D_BITS'(r0_tab) * D_BITS'(r_scale);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld <= 1'b0;
        end else if (w_go1) begin
            r1_vld <= r0_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_go1) begin
            r1_cmd <= r0_cmd;
            r1_neg <= r0_neg;
            r1_mag <= r0_mag;
            r1_d   <= n_d;
        end
    end

    // Stage 2: rounding numerator and divisor for quantize, product for dequantize.
    t_cmd                  r2_cmd;
    logic                  r2_neg;
    logic                  r2_dz;
    logic                  r2_mnz;
    logic [NUM_PAD-1:0]    r2_num;
    logic [DEN_BITS-1:0]   r2_den;
    logic [PROD_BITS-1:0]  r2_prod;
    logic [NUM_PAD-1:0]    n_num;
    logic [PROD_BITS-1:0]  n_prod;

    assign n_num  = (NUM_PAD'(r1_mag) << (SCALE_FRAC_BITS + 1)) + NUM_PAD'(r1_d);
    assign n_prod = PROD_BITS'(r1_mag) * PROD_BITS'(r1_d);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_vld <= 1'b0;
        end else if (w_go2) begin
            r2_vld <= r1_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_go2) begin
            r2_cmd  <= r1_cmd;
            r2_neg  <= r1_neg;
            r2_dz   <= (r1_d == '0);
            r2_mnz  <= (r1_mag != '0);
            r2_num  <= n_num;
            r2_den  <= {r1_d, 1'b0};
            r2_prod <= n_prod;
        end
    end

    // Dequantize rounding and clipping, carried to the end in the divider tag.
    logic [PROD_BITS:0]    w_deq;
    logic [VALUE_BITS-1:0] w_dlim;
    logic                  w_dsat;
    t_tag                  w_tag;

    assign w_deq  = ((PROD_BITS + 1)'(r2_prod) + DEQ_RND) >> SCALE_FRAC_BITS;
    assign w_dlim = r2_neg ? LIM_NEG : LIM_POS;
    assign w_dsat = w_deq > (PROD_BITS + 1)'(w_dlim);

    always_comb begin
        w_tag.cmd  = r2_cmd;
        w_tag.neg  = r2_neg;
        w_tag.dz   = r2_dz;
        w_tag.mnz  = r2_mnz;
        w_tag.dsat = w_dsat;
        w_tag.dmag = w_dsat ? w_dlim : w_deq[VALUE_BITS-1:0];
    end

    // Divider stages.
    logic               w_div_valid;
    logic [NUM_PAD-1:0] w_quot;
    t_tag               w_dtag;

    jcq_div_pipe u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r2_vld),
        .o_ready (w_div_ready),
        .i_num   (r2_num),
        .i_den   (r2_den),
        .i_tag   (w_tag),
        .o_valid (w_div_valid),
        .i_ready (w_out_go),
        .o_quot  (w_quot),
        .o_tag   (w_dtag)
    );

    // Result select, quantize clipping and sign.
    logic [VALUE_BITS-1:0] w_lim;
    logic                  w_qover;
    logic [VALUE_BITS-1:0] w_qmag;
    logic [VALUE_BITS-1:0] w_rmag;
    logic                  w_rsat;
    logic [VALUE_BITS-1:0] n_val;

    assign w_lim   = w_dtag.neg ? LIM_NEG : LIM_POS;
    assign w_qover = w_dtag.dz ? w_dtag.mnz : (w_quot > NUM_PAD'(w_lim));
    assign w_qmag  = w_qover ? w_lim : (w_dtag.dz ? '0 : w_quot[VALUE_BITS-1:0]);

    always_comb begin
        case (w_dtag.cmd)
            CMD_DEQUANT: begin
                w_rmag = w_dtag.dmag;
                w_rsat = w_dtag.dsat;
            end
            default: begin
                w_rmag = w_qmag;
                w_rsat = w_qover;
            end
        endcase
    end

    assign n_val = w_dtag.neg ? (~w_rmag + {{(VALUE_BITS - 1){1'b0}}, 1'b1}) : w_rmag;

    // Output register.
    logic [VALUE_BITS-1:0] r_val;
    logic                  r_sat;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (w_out_go) begin
            r_ov <= w_div_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_go) begin
            r_val <= n_val;
            r_sat <= w_rsat;
        end
    end

    assign o_out.valid     = r_ov;
    assign o_out.value     = r_val;
    assign o_out.saturated = r_sat;

    // A clipped result sits exactly on one of the two range limits.
    a_sat_at_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.saturated) |->
            (o_out.value == LIM_POS || o_out.value == LIM_NEG))
        else $error("saturated result not at a range limit");

    // The input is refused only when every stage up to the output is occupied.
    a_blocked_means_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_in.ready |-> (r0_vld && r1_vld && r2_vld && r_ov))
        else $error("input refused while a stage is empty");

    // No result beat appears in the cycle after reset.
    a_empty_after_reset: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !o_out.valid)
        else $error("result beat right after reset");

    // A zero scale never yields a clipped dequantize result.
    a_deq_zero_scale: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r2_vld && r2_dz && r2_cmd == CMD_DEQUANT) |-> !w_dsat)
        else $error("dequantize with zero scale clipped");

endmodule
